// File: rtl/hpfl_pkg.sv
// ----------------------------------------------------------------------------
// hpfl_pkg
// shared types, codes and constants of the heartbeat pin frame link
// ----------------------------------------------------------------------------
package hpfl_pkg;

	localparam int unsigned FRAME_BYTES = 31;
	localparam int unsigned IDX_W       = $clog2(FRAME_BYTES);
	localparam int unsigned PIN_BYTES   = 16;
	localparam int unsigned HEAD_BYTES  = 7;

	localparam logic [7:0] BYTE_STX     = 8'h02;
	localparam logic [7:0] BYTE_ETX     = 8'h03;
	localparam logic [7:0] BYTE_ADDR    = 8'h01;
	localparam logic [7:0] BYTE_LEN     = 8'h1c;
	localparam logic [7:0] BYTE_CMD     = 8'h30;
	localparam logic [7:0] BYTE_FILL    = 8'h52;
	localparam logic [7:0] BYTE_STATUS  = 8'h81;
	localparam logic [7:0] BYTE_ONE     = 8'h31;
	localparam logic [IDX_W-1:0] IDX_SUM      = IDX_W'(29);
	localparam logic [IDX_W-1:0] IDX_PIN_LO   = IDX_W'(4);
	localparam logic [IDX_W-1:0] IDX_PIN_HI   = IDX_W'(19);
	localparam logic [IDX_W-1:0] IDX_SUM_LO   = IDX_W'(2);
	localparam logic [IDX_W-1:0] IDX_LAST     = IDX_W'(FRAME_BYTES - 1);

	typedef enum logic [1:0] {
		MODE_TICK    = 2'd0,
		MODE_RX      = 2'd1,
		MODE_PIN     = 2'd2,
		MODE_CONNECT = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		KIND_TX     = 2'd0,
		KIND_REJECT = 2'd1,
		KIND_CLOSE  = 2'd2
	} kind_t;

	localparam logic [1:0] REG_SILENCE   = 2'd0;
	localparam logic [1:0] REG_KEEPALIVE = 2'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FRAME,
		ST_CLOSE,
		ST_REJECT
	} state_t;

	typedef struct packed {
		logic start;
		logic with_pin;
		logic step;
	} gen_ctrl_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       last;
	} gen_stat_t;

	typedef struct packed {
		logic check;
		logic status_ok;
		logic busy;
		logic ready;
	} rx_stat_t;

endpackage

// File: rtl/hpfl_frame_gen.sv
// ----------------------------------------------------------------------------
// hpfl_frame_gen
// frame byte sequencer with pin store and one shared checksum adder
// ----------------------------------------------------------------------------
module hpfl_frame_gen
	import hpfl_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  gen_ctrl_t              ctrl,
	input  logic                   pin_wr,
	input  logic [63:0]            pin_chars_high,
	input  logic [47:0]            pin_chars_low,
	input  logic [15:0]            code_chars,
	output gen_stat_t              stat
);

	logic [7:0]       pin_store [PIN_BYTES];
	logic [IDX_W-1:0] idx_q;
	logic [7:0]       sum_q;
	logic             with_pin_q;
	logic [IDX_W-1:0] pin_off;
	logic [7:0]       cur_byte;

	// pin bytes, first char first
	always_ff @(posedge clk) begin
		if (pin_wr) begin
			for (int i = 0; i < 8; i++) pin_store[i] <= pin_chars_high[63-8*i -: 8];
			for (int i = 0; i < 6; i++) pin_store[8+i] <= pin_chars_low[47-8*i -: 8];
			pin_store[14] <= code_chars[15:8];
			pin_store[15] <= code_chars[7:0];
		end
	end

	assign pin_off = idx_q - IDX_PIN_LO;

	always_comb begin
		if (idx_q == IDX_W'(0))                               cur_byte = BYTE_STX;
		else if (idx_q == IDX_W'(1))                          cur_byte = BYTE_ADDR;
		else if (idx_q == IDX_W'(2))                          cur_byte = BYTE_LEN;
		else if (idx_q == IDX_W'(3))                          cur_byte = BYTE_CMD | {7'd0, with_pin_q};
		else if (with_pin_q && idx_q >= IDX_PIN_LO && idx_q <= IDX_PIN_HI)
			cur_byte = pin_store[pin_off[3:0]];
		else if (idx_q == IDX_SUM)                            cur_byte = sum_q;
		else if (idx_q == IDX_LAST)                           cur_byte = BYTE_ETX;
		else                                                  cur_byte = BYTE_FILL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			sum_q      <= '0;
			with_pin_q <= 1'b0;
		end else if (ctrl.start) begin
			idx_q      <= '0;
			sum_q      <= '0;
			with_pin_q <= ctrl.with_pin;
		end else if (ctrl.step) begin
			idx_q <= idx_q + IDX_W'(1);
			// checksum covers bytes 2 up to the one before the sum
			if (idx_q >= IDX_SUM_LO && idx_q < IDX_SUM) sum_q <= sum_q + cur_byte;
		end
	end

	assign stat.tx_byte = cur_byte;
	assign stat.last    = (idx_q == IDX_LAST);

endmodule

// File: rtl/hpfl_rx_check.sv
// ----------------------------------------------------------------------------
// hpfl_rx_check
// keeps the head of a received chunk and decodes the status reply
// ----------------------------------------------------------------------------
module hpfl_rx_check
	import hpfl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_en,
	input  logic       clear,
	input  logic [7:0] rx_byte,
	input  logic       chunk_end,
	output rx_stat_t   stat
);

	logic [7:0] rx_head [HEAD_BYTES];
	logic [2:0] rx_count_q;
	logic       room;
	logic [7:0] last_head;

	assign room = (rx_count_q != 3'(HEAD_BYTES));

	always_ff @(posedge clk) begin
		if (byte_en && room) rx_head[rx_count_q] <= rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_count_q <= '0;
		end else if (clear || (byte_en && chunk_end)) begin
			rx_count_q <= '0;
		end else if (byte_en && room) begin
			rx_count_q <= rx_count_q + 3'd1;
		end
	end

	// the seventh byte may be the one arriving now
	assign last_head = (rx_count_q == 3'(HEAD_BYTES - 1)) ? rx_byte : rx_head[6];

	always_comb begin
		stat.check = byte_en && chunk_end && (rx_count_q >= 3'(HEAD_BYTES - 1))
			&& (rx_head[0] == BYTE_STX) && (last_head == BYTE_ETX);
		stat.status_ok = (rx_head[1] == BYTE_STATUS);
		stat.busy      = (rx_head[3] == BYTE_ONE);
		stat.ready     = (rx_head[4] == BYTE_ONE);
	end

endmodule

// File: rtl/heartbeat_pin_frame_link.sv
// ----------------------------------------------------------------------------
// heartbeat_pin_frame_link
// a tick result passes the state register and then the output register, and items follow
//   one per cycle while the output is not stalled; a frame tick gives 31 bytes plus a close
//   item when the silence limit trips, from the byte sequencer that emits one frame byte per cycle
// no new input is taken while a frame, close or reject item is still to be loaded
// reset: link down, flags and counters cleared, limits back to 16 and 5
// ----------------------------------------------------------------------------
module heartbeat_pin_frame_link
	import hpfl_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	// input stream
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [135:0] s_axis_tdata,  // rx_byte, pin_chars_high, pin_chars_low, code_chars
	input  logic         s_axis_tlast,  // chunk_end
	input  logic [1:0]   s_axis_tuser,  // mode
	// output stream
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [15:0]  m_axis_tdata,  // tx_data, slave_busy, slave_ready, pin_waiting, zero fill
	output logic         m_axis_tlast,  // frame_last
	output logic [1:0]   m_axis_tuser,  // kind
	// register writes
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [5:0]   cfg_data
);

	// unpacked input fields
	logic [1:0]  in_mode;
	logic [7:0]  in_rx_byte;
	logic [63:0] in_pin_hi;
	logic [47:0] in_pin_lo;
	logic [15:0] in_code;

	assign in_mode    = s_axis_tuser;
	assign in_rx_byte = s_axis_tdata[7:0];
	assign in_pin_hi  = s_axis_tdata[71:8];
	assign in_pin_lo  = s_axis_tdata[119:72];
	assign in_code    = s_axis_tdata[135:120];

	// link state
	state_t     state_q, state_nx;
	logic       link_up_q, busy_q, ready_q, pin_pending_q, close_q;
	logic [5:0] silence_q, silence_limit_q;
	logic [3:0] alive_q, keepalive_q;

	// output register
	logic       out_valid_q;
	logic [1:0] out_kind_q;
	logic [7:0] out_data_q;
	logic       out_last_q, out_busy_q, out_ready_q, out_pin_q;

	// handshakes and per-tick decisions
	logic       accept, out_free;
	logic       tick_go, rx_go, pin_go, conn_go, pin_ok;
	logic [6:0] sn;
	logic [4:0] an;
	logic       t_send, t_close;
	logic [3:0] alive_nx;

	// sequencer outputs
	logic       load;
	logic [1:0] load_kind;
	logic [7:0] load_data;
	logic       load_last;

	gen_ctrl_t  gen_ctrl;
	gen_stat_t  gen_stat;
	rx_stat_t   rx_stat;

	assign cfg_ready = 1'b1;
	assign accept    = s_axis_tvalid && s_axis_tready;
	assign out_free  = !out_valid_q || m_axis_tready;

	assign tick_go = accept && (in_mode == MODE_TICK) && link_up_q;
	assign rx_go   = accept && (in_mode == MODE_RX) && link_up_q;
	assign pin_go  = accept && (in_mode == MODE_PIN);
	assign conn_go = accept && (in_mode == MODE_CONNECT);
	assign pin_ok  = !busy_q && ready_q;

	// counters are compared one bit wider so a full count still trips
	assign sn = {1'b0, silence_q} + 7'd1;
	assign an = {1'b0, alive_q} + 5'd1;

	always_comb begin
		t_send   = 1'b0;
		alive_nx = an[3:0];
		if (pin_pending_q) begin
			t_send   = 1'b1;
			alive_nx = an[4] ? 4'hf : an[3:0];
		end else if (an > {1'b0, keepalive_q}) begin
			t_send   = 1'b1;
			alive_nx = '0;
		end
		t_close = (sn > {1'b0, silence_limit_q});
	end

	// frame sequencer with shared checksum adder
	hpfl_frame_gen u_gen (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (gen_ctrl),
		.pin_wr         (pin_go && pin_ok),
		.pin_chars_high (in_pin_hi),
		.pin_chars_low  (in_pin_lo),
		.code_chars     (in_code),
		.stat           (gen_stat)
	);

	// received chunk head and status decode
	hpfl_rx_check u_rx (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_en   (rx_go),
		.clear     (conn_go),
		.rx_byte   (in_rx_byte),
		.chunk_end (s_axis_tlast),
		.stat      (rx_stat)
	);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (tick_go && t_send)       state_nx = ST_FRAME;
				else if (tick_go && t_close) state_nx = ST_CLOSE;
				else if (pin_go && !pin_ok)  state_nx = ST_REJECT;
			end
			ST_FRAME: begin
				if (out_free && gen_stat.last) state_nx = close_q ? ST_CLOSE : ST_IDLE;
			end
			ST_CLOSE, ST_REJECT: begin
				if (out_free) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_axis_tready     = 1'b0;
		gen_ctrl.start    = 1'b0;
		gen_ctrl.with_pin = pin_pending_q;
		gen_ctrl.step     = 1'b0;
		load              = 1'b0;
		load_kind         = KIND_TX;
		load_data         = 8'd0;
		load_last         = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready  = 1'b1;
				gen_ctrl.start = tick_go;
			end
			ST_FRAME: begin
				load          = out_free;
				gen_ctrl.step = out_free;
				load_data     = gen_stat.tx_byte;
				load_last     = gen_stat.last && !close_q;
			end
			ST_CLOSE: begin
				load      = out_free;
				load_kind = KIND_CLOSE;
			end
			ST_REJECT: begin
				load      = out_free;
				load_kind = KIND_REJECT;
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			link_up_q       <= 1'b0;
			busy_q          <= 1'b0;
			ready_q         <= 1'b0;
			pin_pending_q   <= 1'b0;
			close_q         <= 1'b0;
			silence_q       <= '0;
			alive_q         <= '0;
			silence_limit_q <= 6'd16;
			keepalive_q     <= 4'd5;
			out_valid_q     <= 1'b0;
		end else begin
			state_q <= state_nx;

			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_SILENCE)   silence_limit_q <= cfg_data;
				if (cfg_index == REG_KEEPALIVE) keepalive_q     <= cfg_data[3:0];
			end

			if (tick_go) begin
				alive_q   <= alive_nx;
				silence_q <= t_close ? 6'd0 : sn[5:0];
				close_q   <= t_close;
				if (t_close) link_up_q <= 1'b0;
			end

			// any byte on a live link ends the silence
			if (rx_go) silence_q <= '0;
			if (rx_stat.check) begin
				if (rx_stat.status_ok) begin
					busy_q  <= rx_stat.busy;
					ready_q <= rx_stat.ready;
				end else begin
					pin_pending_q <= 1'b0;
				end
			end

			if (pin_go && pin_ok) pin_pending_q <= 1'b1;

			if (conn_go) begin
				link_up_q <= 1'b1;
				silence_q <= '0;
				alive_q   <= '0;
			end

			if (load)               out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	// output payload, flags as they stand when the item is made
	always_ff @(posedge clk) begin
		if (load) begin
			out_kind_q  <= load_kind;
			out_data_q  <= load_data;
			out_last_q  <= load_last;
			out_busy_q  <= busy_q;
			out_ready_q <= ready_q;
			out_pin_q   <= pin_pending_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {5'd0, out_pin_q, out_ready_q, out_busy_q, out_data_q};

endmodule
